// ----- sv/gdsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdsd_pkg: shared constants of the gradient-direction second derivative unit
// Field widths, register indexes and reset values of the configuration port.
// ----------------------------------------------------------------------------
package gdsd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int COEF_BITS_DEFAULT = 12;

  // Fixed field widths
  localparam int ROW_BITS       = 12;
  localparam int COL_BITS       = 11;
  localparam int DIM_BITS       = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int VALUE_BITS     = 48;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Register reset values and limits
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [DIM_BITS-1:0] DIM_MIN      = 12'd3;
  localparam int                  DIM_LIMIT    = 4095;

endpackage
`default_nettype wire

// ----- sv/gradient_direction_second_derivative_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_direction_second_derivative_unit: second derivative along gradient
// Streams spline coefficients in raster order and returns, per pixel, the
// exact integer R*P*P + 3*S*P*Q + T*Q*Q (864 times the derivative).
// ----------------------------------------------------------------------------
// Coefficients of one frame enter in raster order, one per input transaction.
// Both line stores live in a single synchronous memory of MAX_WIDTH entries,
// each entry holding the two previous rows of one column; the item's column is
// read on acceptance, and in the next cycle the entry is rotated and written back
// while the 3x3 window shifts. The stencil sums, the products PP, PQ and QQ, the
// three triple products and the saturating sum then take one registered stage
// each, and the results leave through an output register, one per cycle while
// out_ready is high. The unit works on one item at a time: after acceptance it
// passes the READ, ADD, SQ, MUL and SUM stages, then waits in EMIT until the n
// results it causes (0 to 3) have gone into the single output register, and only
// then comes the next acceptance. The next item is taken
// while the last result still waits in the output register. Results lag by one
// row: the item at (r, c) returns pixel (r-1, c-1) when r and c are at least 1,
// then the zero of pixel (r-1, width-1) at the end of a row, then on the last
// row the zero of pixel (r, c). Border pixels read zero and frame_last marks
// the bottom-right pixel. A width or height write restarts the frame at (0, 0);
// widths saturate into [3, MAX_WIDTH] and heights into [3, 4095]. There is no
// clearing pass after reset: entries never written only feed border pixels.
// ----------------------------------------------------------------------------
module gradient_direction_second_derivative_unit #(
  parameter int MAX_WIDTH = gdsd_pkg::MAX_WIDTH_DEFAULT,
  parameter int COEF_BITS = gdsd_pkg::COEF_BITS_DEFAULT
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // Coefficient stream
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  signed [COEF_BITS-1:0]              coefficient,
  // Result stream
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic        [gdsd_pkg::ROW_BITS-1:0]     out_row,
  output logic        [gdsd_pkg::COL_BITS-1:0]     out_column,
  output logic signed [gdsd_pkg::VALUE_BITS-1:0]   value,
  output logic                                     frame_last,
  // Configuration writes
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire         [gdsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire         [gdsd_pkg::DIM_BITS-1:0]     cfg_data
);

  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DB        = gdsd_pkg::DIM_BITS;
  localparam int RB        = gdsd_pkg::ROW_BITS;
  localparam int CB        = gdsd_pkg::COL_BITS;
  localparam int VB        = gdsd_pkg::VALUE_BITS;
  // Stencil terms, squares and triple products
  localparam int D1        = COEF_BITS + 5;
  localparam int D2        = 2 * D1;
  localparam int D3        = 3 * D1;
  localparam int SUMW      = D3 + 2;
  localparam int WW        = (SUMW > VB) ? SUMW : VB;
  localparam int WIDTH_CAP = (MAX_WIDTH < gdsd_pkg::DIM_LIMIT) ? MAX_WIDTH
                                                                : gdsd_pkg::DIM_LIMIT;
  localparam logic [DB-1:0] WIDTH_MAX = DB'(WIDTH_CAP);

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;

  // Configuration and frame position
  logic [DB-1:0] image_width;
  logic [DB-1:0] image_height;
  logic [DB-1:0] column_count;
  logic [DB-1:0] row_count;

  // Item held while it is worked on
  logic signed [COEF_BITS-1:0] item_coef;
  logic [DB-1:0]               item_col;
  logic [DB-1:0]               item_row;
  logic                        item_last;
  logic                        deriv_on;
  logic [2:0]                  pending;

  // Line store: upper half holds row r-1, lower half row r-2
  logic [2*COEF_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*COEF_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [ADDR_BITS-1:0]   wr_addr;

  // 3x3 window, index row*3 + column, row 0 on top, column 0 on the left
  logic signed [COEF_BITS-1:0] win [9];

  // Arithmetic stages
  logic signed [D1-1:0] p_term, q_term, r_term, s3_term, t_term;
  logic signed [D1-1:0] p_next, q_next, r_next, s3_next, t_next;
  logic signed [D2-1:0] pp, pq, qq;
  logic signed [D3-1:0] rpp, spq, tqq;
  logic signed [VB-1:0] deriv;
  logic signed [WW-1:0] sum_wide;
  logic signed [WW-1:0] sat_hi;
  logic signed [WW-1:0] sat_lo;

  logic in_acc;
  logic cfg_acc;
  logic [DB:0] col_plus;
  logic [DB:0] row_plus;
  logic        col_last;
  logic        row_last;
  logic        out_free;
  logic [2:0]  pend_low;
  logic [DB-1:0] cfg_width_sat;
  logic [DB-1:0] cfg_height_sat;

  // ---------------------------------------------------------------------------
  // Handshakes: take a configuration write in preference to a coefficient
  // ---------------------------------------------------------------------------
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  assign col_plus = {1'b0, column_count} + (DB+1)'(1);
  assign row_plus = {1'b0, row_count} + (DB+1)'(1);
  assign col_last = (col_plus == {1'b0, image_width});
  assign row_last = (row_plus == {1'b0, image_height});

  // Saturate written dimensions into their legal ranges
  always_comb begin
    cfg_width_sat = cfg_data;
    if (cfg_data > WIDTH_MAX) begin
      cfg_width_sat = WIDTH_MAX;
    end
    if (cfg_data < gdsd_pkg::DIM_MIN) begin
      cfg_width_sat = gdsd_pkg::DIM_MIN;
    end
    cfg_height_sat = cfg_data;
    if (cfg_data < gdsd_pkg::DIM_MIN) begin
      cfg_height_sat = gdsd_pkg::DIM_MIN;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers and frame position; advance on every accepted coefficient
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gdsd_pkg::WIDTH_RESET;
      image_height <= gdsd_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        gdsd_pkg::REG_IMAGE_WIDTH: begin
          image_width  <= cfg_width_sat;
          column_count <= '0;
          row_count    <= '0;
        end
        gdsd_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= cfg_height_sat;
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end else if (in_acc) begin
      if (col_plus >= {1'b0, image_width}) begin
        column_count <= '0;
        row_count    <= (row_plus >= {1'b0, image_height}) ? '0 : row_plus[DB-1:0];
      end else begin
        column_count <= col_plus[DB-1:0];
      end
    end
  end

  // Latch the item and decide which results it causes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_coef <= coefficient;
      item_col  <= column_count;
      item_row  <= row_count;
      item_last <= col_last;
      deriv_on  <= (row_count >= DB'(2)) && (column_count >= DB'(2));
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read on acceptance, rotate and write back in the next cycle.
  // Only one item is in flight, so a read never meets a pending write.
  // ---------------------------------------------------------------------------
  assign rd_addr = ADDR_BITS'(column_count);
  assign wr_addr = ADDR_BITS'(item_col);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      line_mem[wr_addr] <= {item_coef, rd_data[2*COEF_BITS-1:COEF_BITS]};
    end
    if (in_acc) begin
      rd_data <= line_mem[rd_addr];
    end
  end

  // Shift the window left and bring in the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (state == S_READ) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]     <= win[k*3 + 1];
        win[k*3 + 1] <= win[k*3 + 2];
      end
      win[2] <= signed'(rd_data[COEF_BITS-1:0]);
      win[5] <= signed'(rd_data[2*COEF_BITS-1:COEF_BITS]);
      win[8] <= item_coef;
    end
  end

  // ---------------------------------------------------------------------------
  // Stencil sums
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [D1-1:0] cl, cc, cr, ru, rc, rd;
    cl = D1'(win[0]) + (D1'(win[3]) <<< 2) + D1'(win[6]);
    cc = D1'(win[1]) + (D1'(win[4]) <<< 2) + D1'(win[7]);
    cr = D1'(win[2]) + (D1'(win[5]) <<< 2) + D1'(win[8]);
    ru = D1'(win[0]) + (D1'(win[1]) <<< 2) + D1'(win[2]);
    rc = D1'(win[3]) + (D1'(win[4]) <<< 2) + D1'(win[5]);
    rd = D1'(win[6]) + (D1'(win[7]) <<< 2) + D1'(win[8]);
    p_next  = cr - cl;
    q_next  = rd - ru;
    r_next  = cl - (cc <<< 1) + cr;
    t_next  = rd - (rc <<< 1) + ru;
    s3_next = D1'(3 * ((D1'(win[8]) - D1'(win[6])) + (D1'(win[0]) - D1'(win[2]))));
  end

  assign sum_wide = WW'(rpp) + WW'(spq) + WW'(tqq);
  assign sat_hi   = WW'(48'sh7FFF_FFFF_FFFF);
  assign sat_lo   = WW'(48'sh8000_0000_0000);

  // One registered stage per step of the product chain
  always_ff @(posedge clk) begin
    if (state == S_ADD) begin
      p_term  <= p_next;
      q_term  <= q_next;
      r_term  <= r_next;
      s3_term <= s3_next;
      t_term  <= t_next;
    end
    if (state == S_SQ) begin
      pp <= D2'(p_term) * D2'(p_term);
      pq <= D2'(p_term) * D2'(q_term);
      qq <= D2'(q_term) * D2'(q_term);
    end
    if (state == S_MUL) begin
      rpp <= D3'(r_term) * D3'(pp);
      spq <= D3'(s3_term) * D3'(pq);
      tqq <= D3'(t_term) * D3'(qq);
    end
    if (state == S_SUM) begin
      if (sum_wide > sat_hi) begin
        deriv <= sat_hi[VB-1:0];
      end else if (sum_wide < sat_lo) begin
        deriv <= sat_lo[VB-1:0];
      end else begin
        deriv <= sum_wide[VB-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: walk the item through the stages, then hand out its results
  // ---------------------------------------------------------------------------
  assign pend_low = pending & (~pending + 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state   <= S_READ;
            pending <= {row_last,
                        (row_count != '0) && col_last,
                        (row_count != '0) && (column_count != '0)};
          end
        end
        S_READ:  state <= S_ADD;
        S_ADD:   state <= S_SQ;
        S_SQ:    state <= S_MUL;
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_EMIT;
        S_EMIT: begin
          if (pending == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pending <= pending & ~pend_low;
            if ((pending & ~pend_low) == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load the earliest pending result, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && pending != '0 && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && pending != '0 && out_free) begin
      if (pending[0]) begin
        out_row    <= RB'(item_row - DB'(1));
        out_column <= CB'(item_col - DB'(1));
        value      <= deriv_on ? deriv : '0;
        frame_last <= 1'b0;
      end else if (pending[1]) begin
        out_row    <= RB'(item_row - DB'(1));
        out_column <= CB'(item_col);
        value      <= '0;
        frame_last <= 1'b0;
      end else begin
        out_row    <= RB'(item_row);
        out_column <= CB'(item_col);
        value      <= '0;
        frame_last <= item_last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_column_in_frame: assert property (@(posedge clk) disable iff (rst)
    column_count < image_width)
    else $error("column position left the frame");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row_count < image_height)
    else $error("row position left the frame");

  a_last_at_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      (RB'(out_row) == image_height - DB'(1)) &&
      (DB'(out_column) == image_width - DB'(1)))
    else $error("frame_last away from the bottom-right pixel");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ && !in_ready)
    else $error("coefficient taken while an item is in flight");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gradient_direction_second_derivative_unit
// Streams spline coefficients through frames of many shapes and compares
// every returned pixel (row, column, curvature numerator, frame end) with a
// bit-exact prediction of the line stores, the 3x3 window and the
// one-row-late result schedule. Both ends stall at random. The frame shape
// registers are changed between phases, including out-of-range and unknown
// writes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COEF_BITS = gdsd_pkg::COEF_BITS_DEFAULT;
  localparam int MAX_W     = gdsd_pkg::MAX_WIDTH_DEFAULT;

  typedef logic signed [COEF_BITS-1:0]                coef_t;
  typedef logic        [gdsd_pkg::ROW_BITS-1:0]       row_t;
  typedef logic        [gdsd_pkg::COL_BITS-1:0]       col_t;
  typedef logic signed [gdsd_pkg::VALUE_BITS-1:0]     val_t;
  typedef logic        [gdsd_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic        [gdsd_pkg::DIM_BITS-1:0]       dim_t;

  // One returned pixel, as the block presents it
  typedef struct packed {
    row_t row;
    col_t column;
    val_t value;
    logic last;
  } pixel_t;

  // Register indexes the block does not implement: writes to them are dropped
  localparam cfg_index_t REG_SPARE_LOW  = 2'd2;
  localparam cfg_index_t REG_SPARE_HIGH = 2'd3;

  localparam coef_t  COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam coef_t  COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam longint NUM_TOP  = (longint'(1) <<< (gdsd_pkg::VALUE_BITS-1)) - 1;
  localparam longint NUM_BOT  = -NUM_TOP - 1;

  localparam int RANDOM_ITEMS    = 394;  // with the directed opening, 420 in all
  localparam int QUIET_ITEMS     = 60;   // last part of the run without idling
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the line stores and window, queues awaited pixels
  // --------------------------------------------------------------------------
  class curvature_scoreboard;
    coef_t       older_row [MAX_W];
    coef_t       newer_row [MAX_W];
    coef_t       window [9];        // [row*3 + col], row 0 = up, col 0 = left
    int unsigned row_at;
    int unsigned column_at;
    int unsigned width;
    int unsigned height;
    pixel_t      awaited_pixels [$];
    int          mismatches;
    int          pixels_checked;
    int          frame_ends;

    function new();
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (window[i]) window[i] = '0;
      row_at         = 0;
      column_at      = 0;
      width          = gdsd_pkg::WIDTH_RESET;
      height         = gdsd_pkg::HEIGHT_RESET;
      mismatches     = 0;
      pixels_checked = 0;
      frame_ends     = 0;
    endfunction

    function int pending();
      return awaited_pixels.size();
    endfunction

    function void apply_register(cfg_index_t idx, dim_t data);
      int unsigned v;
      v = data;
      case (idx)
        gdsd_pkg::REG_IMAGE_WIDTH: begin
          if (v > MAX_W) v = MAX_W;
          if (v < gdsd_pkg::DIM_MIN) v = gdsd_pkg::DIM_MIN;
          width = v;
        end
        gdsd_pkg::REG_IMAGE_HEIGHT: begin
          if (v < gdsd_pkg::DIM_MIN) v = gdsd_pkg::DIM_MIN;
          height = v;
        end
        default: return;
      endcase
      row_at    = 0;
      column_at = 0;
    endfunction

    // R*P*P + 3*S*P*Q + T*Q*Q from the raw stencil sums of the window
    function longint curvature_numerator();
      longint w [9];
      longint cl, cc, cr, ru, rc, rd, p, q, r, s, t, v;
      foreach (window[i]) w[i] = longint'(window[i]);
      cl = w[0] + 4 * w[3] + w[6];
      cc = w[1] + 4 * w[4] + w[7];
      cr = w[2] + 4 * w[5] + w[8];
      ru = w[0] + 4 * w[1] + w[2];
      rc = w[3] + 4 * w[4] + w[5];
      rd = w[6] + 4 * w[7] + w[8];
      p  = cr - cl;
      q  = rd - ru;
      r  = cl - 2 * cc + cr;
      s  = (w[8] - w[6]) + (w[0] - w[2]);
      t  = rd - 2 * rc + ru;
      v  = r * p * p + 3 * s * p * q + t * q * q;
      if (v > NUM_TOP) v = NUM_TOP;
      if (v < NUM_BOT) v = NUM_BOT;
      return v;
    endfunction

    function void await_pixel(int unsigned r, int unsigned c, longint v, bit last);
      pixel_t px;
      px.row    = row_t'(r);
      px.column = col_t'(c);
      px.value  = val_t'(v);
      px.last   = last;
      awaited_pixels.push_back(px);
    endfunction

    // Advance the frame by one accepted coefficient and queue what it releases
    function void note_coefficient(coef_t x);
      int unsigned r, c;
      coef_t       above2, above1;
      r      = row_at;
      c      = column_at;
      above2 = '0;
      above1 = '0;
      if (c < MAX_W) begin
        above2       = older_row[c];
        above1       = newer_row[c];
        older_row[c] = above1;
        newer_row[c] = x;
      end
      for (int k = 0; k < 3; k++) begin
        window[k*3]     = window[k*3 + 1];
        window[k*3 + 1] = window[k*3 + 2];
      end
      window[2] = above2;
      window[5] = above1;
      window[8] = x;

      if (r >= 1 && c >= 1)
        await_pixel(r - 1, c - 1, (r >= 2 && c >= 2) ? curvature_numerator() : 0, 1'b0);
      if (r >= 1 && c + 1 == width)
        await_pixel(r - 1, c, 0, 1'b0);
      if (r + 1 == height)
        await_pixel(r, c, 0, c + 1 == width);

      if (c + 1 >= width) begin
        column_at = 0;
        row_at    = (r + 1 >= height) ? 0 : r + 1;
      end else begin
        column_at = c + 1;
      end
    endfunction

    function void check_pixel(row_t row, col_t column, val_t val, logic last);
      pixel_t want;
      if (awaited_pixels.size() == 0) begin
        $error("pixel (%0d, %0d) returned with nothing awaited", row, column);
        mismatches++;
        return;
      end
      want = awaited_pixels.pop_front();
      pixels_checked++;
      if (row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, row);
        mismatches++;
      end
      if (column !== want.column) begin
        $error("out_column: expected %0d, got %0d", want.column, column);
        mismatches++;
      end
      if (val !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, val);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("frame_last: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
      if (want.last) frame_ends++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared control
  // --------------------------------------------------------------------------
  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  coef_t      coefficient = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  row_t       out_row;
  col_t       out_column;
  val_t       value;
  logic       frame_last;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index   = gdsd_pkg::REG_IMAGE_WIDTH;
  dim_t       cfg_data    = '0;

  curvature_scoreboard board = new();

  bit quiet_tail       = 1'b0;   // no idling on either side once set
  bit hold_off_request = 1'b0;   // asks the result side for one long hold-off
  int coefficients_sent = 0;
  int registers_written = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gradient_direction_second_derivative_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .coefficient(coefficient),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_column (out_column),
    .value      (value),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one coefficient, after an optional random gap, and hold it until the
  // transaction completes. Valid is left high so back-to-back items never dip.
  task automatic send_coefficient(input coef_t x);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    coefficient <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_coefficient(x);
    coefficients_sent++;
  endtask

  // Drop valid once a burst of coefficients is done
  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Hold the input back until every awaited pixel is home, then let the
  // pipeline empty of items that release no pixel at all.
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register transaction; keep valid up when another write follows
  task automatic write_register(input cfg_index_t idx, input dim_t data,
                                input bit drop_after);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.apply_register(idx, data);
    registers_written++;
    if (drop_after) cfg_valid <= 1'b0;
  endtask

  // Extremes often, the whole range otherwise
  function automatic coef_t random_coefficient();
    case ($urandom_range(0, 7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return coef_t'(0);
      3:       return coef_t'(-1);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Mostly a small legal size; now and then an extreme or random value that may need saturating
  function automatic dim_t random_dimension(input int lo, input int hi);
    if ($urandom_range(0, 9) != 0) return dim_t'($urandom_range(lo, hi));
    case ($urandom_range(0, 3))
      0:       return dim_t'($urandom_range(0, 2));
      1:       return dim_t'(gdsd_pkg::DIM_LIMIT);
      2:       return dim_t'($urandom_range(MAX_W + 1, gdsd_pkg::DIM_LIMIT));
      default: return dim_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check every transaction, stall in bursts, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        board.check_pixel(out_row, out_column, value, frame_last);
      if (hold_off_request) begin
        // Hold off long enough for the output register to fill and the
        // input side to back up behind it
        stall_left       = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction of any kind completes for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("gradient_direction_second_derivative_unit verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    coef_t       corner_frame [9];
    int          random_sent;
    int          phase;
    int          items;
    int          split;
    int          choice;
    int unsigned area;
    dim_t        width_data;
    dim_t        height_data;
    bit          hold_off_done;

    corner_frame = '{COEF_MAX, COEF_MIN, coef_t'(0),
                     coef_t'(-1), COEF_MAX, COEF_MIN,
                     coef_t'(0), COEF_MAX, coef_t'(-1)};
    hold_off_done = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A couple of items at the reset frame shape: row 0 of a wide frame,
    // nothing comes back, so let the pipeline empty before reconfiguring
    send_coefficient(COEF_MAX);
    send_coefficient(COEF_MIN);
    end_burst();
    settle();

    // Undersized width and height both saturate to 3: a single 3x3 frame
    // with one interior pixel built from the field extremes
    write_register(gdsd_pkg::REG_IMAGE_WIDTH, dim_t'(1), 1'b0);
    write_register(gdsd_pkg::REG_IMAGE_HEIGHT, dim_t'(0), 1'b1);
    foreach (corner_frame[i]) send_coefficient(corner_frame[i]);
    end_burst();
    settle();

    // Oversized width saturates to the line store depth; tallest height.
    // Only the start of row 0 is fed, the next write restarts the frame.
    write_register(gdsd_pkg::REG_IMAGE_WIDTH, dim_t'(gdsd_pkg::DIM_LIMIT), 1'b0);
    write_register(gdsd_pkg::REG_IMAGE_HEIGHT, dim_t'(gdsd_pkg::DIM_LIMIT), 1'b1);
    repeat (4) send_coefficient(random_coefficient());
    end_burst();
    settle();

    // Writes to unknown indexes mid-frame must neither change the shape nor
    // restart the frame: the second half continues where the first stopped
    write_register(gdsd_pkg::REG_IMAGE_WIDTH, dim_t'(5), 1'b0);
    write_register(gdsd_pkg::REG_IMAGE_HEIGHT, dim_t'(4), 1'b1);
    repeat (6) send_coefficient(random_coefficient());
    end_burst();
    settle();
    write_register(REG_SPARE_LOW, dim_t'(gdsd_pkg::DIM_LIMIT), 1'b0);
    write_register(REG_SPARE_HIGH, dim_t'(0), 1'b1);
    repeat (5) send_coefficient(random_coefficient());
    end_burst();
    settle();

    // Random phases: a new frame shape each time, whole frames mostly,
    // sometimes a frame cut short by the next write
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiet_tail  = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      width_data  = random_dimension(3, 9);
      height_data = random_dimension(3, 6);
      choice      = $urandom_range(0, 3);
      case (choice)
        1:       write_register(gdsd_pkg::REG_IMAGE_HEIGHT, height_data, 1'b1);
        2:       write_register(gdsd_pkg::REG_IMAGE_WIDTH, width_data, 1'b1);
        default: begin
          write_register(gdsd_pkg::REG_IMAGE_WIDTH, width_data, 1'b0);
          write_register(gdsd_pkg::REG_IMAGE_HEIGHT, height_data, 1'b1);
        end
      endcase

      // Huge shapes only get a short partial run
      area = board.width * board.height;
      if (board.width > 16 || board.height > 16) begin
        items = $urandom_range(8, 40);
      end else begin
        items = area * $urandom_range(1, 2);
        if ($urandom_range(0, 2) == 0) items += $urandom_range(1, area - 1);
      end
      if (items > RANDOM_ITEMS - random_sent) items = RANDOM_ITEMS - random_sent;
      split = (items > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, items - 1) : 0;

      // Once, early on: starve the output while the input keeps offering,
      // on a small frame that certainly releases pixels
      if (!hold_off_done && phase >= 1 && board.width <= 16 && board.height <= 16 &&
          items >= board.width + 2) begin
        hold_off_request = 1'b1;
        hold_off_done    = 1'b1;
      end

      for (int i = 0; i < items; i++) begin
        if (split != 0 && i == split) begin
          // Pause, drop a write on an unknown index, carry on mid-frame
          end_burst();
          settle();
          write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                         dim_t'($urandom), 1'b1);
        end
        send_coefficient(random_coefficient());
      end
      end_burst();
      settle();
      random_sent += items;
      phase++;
    end

    if (board.pending() != 0) begin
      $error("%0d pixels never returned", board.pending());
      board.mismatches++;
    end

    $display("Covered %0d coefficients in %0d phases, %0d pixels checked, %0d frames closed,",
             coefficients_sent, phase, board.pixels_checked, board.frame_ends);
    $display("%0d register writes including saturated and unknown ones, one long hold-off.",
             registers_written);
    if (board.mismatches == 0) begin
      $display("gradient_direction_second_derivative_unit verification clean");
    end else begin
      $display("gradient_direction_second_derivative_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
